### hdl/dtha_pkg.sv
// dtha_pkg: shared constants, codes and types of the device table with two-hit admission
// no dependencies
`default_nettype none

package dtha_pkg;

    localparam int DEF_DEVICE_SLOTS  = 24;
    localparam int DEF_PENDING_SLOTS = 8;
    localparam int DEF_ENTRY_SLOTS   = 32;
    localparam int DEF_KEY_BITS      = 64;

    localparam int FUNC_W    = 2;
    localparam int KEYIN_W   = 64;
    localparam int KIND_W    = 16;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 5;
    localparam int COUNT_W   = 32;
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_RECORD = 2'd0,
        FN_SWEEP  = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_PENDING   = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_NO_ROOM   = 3'd4,
        ST_SWEPT     = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WINDOW  = 2'd1;

endpackage

`default_nettype wire

### hdl/device_table_two_hit_admission_top.sv
// device table with two-hit admission filter: top level, sequencer and tables
// depends on dtha_pkg
//
// One beat on the input stream is one command: a record sighting, a sweep of stale
// devices and entries, or a clear of all tables. The block takes one command at a time
// and is not ready while it works. A single compare and update datapath walks the tables
// one slot per cycle under a small sequencer. A well-formed sighting makes a pass over
// the device table, a pass over the pending table for a decode from an unknown device,
// then, unless it ends there as pending or too long, a pass over the entry table. A
// sweep makes a device pass when device_window is nonzero, an entry pass if any device
// aged out, then, when entry_window is nonzero, an entry pass with an owner check pass
// for each entry that ages out. Every command but func 3 gives exactly one result beat;
// the result waits in an output register, so the next command is accepted while it is
// still held. Configuration writes (device_window, entry_window) are taken at any time
// on the cfg channel and must only be issued while the block is idle.
`default_nettype none

module device_table_two_hit_admission_top #(
    parameter int DEVICE_SLOTS  = dtha_pkg::DEF_DEVICE_SLOTS,
    parameter int PENDING_SLOTS = dtha_pkg::DEF_PENDING_SLOTS,
    parameter int ENTRY_SLOTS   = dtha_pkg::DEF_ENTRY_SLOTS,
    parameter int KEY_BITS      = dtha_pkg::DEF_KEY_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // entry_key[63:0], msg_kind[79:64], well_formed[80], fits[81], now[113:82], zero pad
    input  wire logic [dtha_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func[1:0], is_decode[2]
    input  wire logic [dtha_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // device_slot[4:0], entry_slot[9:5], seen_count[41:10], devices_held[46:42],
    // drops[78:47], decodes_stored[110:79], zero pad
    output logic [dtha_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // status[2:0]
    output logic [dtha_pkg::OUT_USER_W-1:0]         m_axis_tuser,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dtha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dtha_pkg::TIME_W-1:0]        i_cfg_data
);
    import dtha_pkg::*;

    localparam int DW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int EW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int HW = $clog2(DEVICE_SLOTS + 1);

    localparam logic [DW-1:0] DEV_LAST = DW'(DEVICE_SLOTS - 1);
    localparam logic [PW-1:0] PEN_LAST = PW'(PENDING_SLOTS - 1);
    localparam logic [EW-1:0] ENT_LAST = EW'(ENTRY_SLOTS - 1);

    // sequencer states, one-hot
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_DSCAN  = 13'b0_0000_0000_0010,
        S_DDEC   = 13'b0_0000_0000_0100,
        S_PSCAN  = 13'b0_0000_0000_1000,
        S_PDEC   = 13'b0_0000_0001_0000,
        S_POST   = 13'b0_0000_0010_0000,
        S_ESCAN  = 13'b0_0000_0100_0000,
        S_EDEC   = 13'b0_0000_1000_0000,
        S_SWDEV  = 13'b0_0001_0000_0000,
        S_SWDFR  = 13'b0_0010_0000_0000,
        S_SWENT  = 13'b0_0100_0000_0000,
        S_SWECHK = 13'b0_1000_0000_0000,
        S_DONE   = 13'b1_0000_0000_0000
    } t_state;

    // configuration registers
    logic [TIME_W-1:0] r_dev_win, r_ent_win;

    // tables
    logic [DEVICE_SLOTS-1:0]  r_dev_valid;
    logic [KEY_BITS-1:0]      r_dev_key   [DEVICE_SLOTS];
    logic [COUNT_W-1:0]       r_dev_hits  [DEVICE_SLOTS];
    logic [TIME_W-1:0]        r_dev_time  [DEVICE_SLOTS];
    logic [COUNT_W-1:0]       r_dev_order [DEVICE_SLOTS];
    logic [PENDING_SLOTS-1:0] r_wait_valid;
    logic [KEY_BITS-1:0]      r_wait_key   [PENDING_SLOTS];
    logic [COUNT_W-1:0]       r_wait_order [PENDING_SLOTS];
    logic [ENTRY_SLOTS-1:0]   r_ent_valid;
    logic [DW-1:0]            r_ent_owner [ENTRY_SLOTS];
    logic [KIND_W-1:0]        r_ent_kind  [ENTRY_SLOTS];
    logic [TIME_W-1:0]        r_ent_time  [ENTRY_SLOTS];
    logic [COUNT_W-1:0]       r_ent_order [ENTRY_SLOTS];
    logic [COUNT_W-1:0]       r_order_cnt;
    logic [HW-1:0]            r_held;
    logic [COUNT_W-1:0]       r_drops;
    logic [COUNT_W-1:0]       r_decodes;

    // latched command
    t_state             r_state;
    logic [KEY_BITS-1:0] r_key;
    logic [KIND_W-1:0]  r_kind;
    logic               r_dec, r_fits;
    logic [TIME_W-1:0]  r_now;

    // scan state
    logic [DW-1:0] r_di, r_dsel, r_dfree, r_dlru;
    logic          r_dfound, r_dfree_ok, r_evict;
    logic [PW-1:0] r_pi, r_pmatch, r_pfree, r_plru;
    logic          r_pmatch_ok, r_pfree_ok;
    logic [EW-1:0] r_ei, r_ematch, r_efree, r_ebest, r_ej;
    logic          r_ematch_ok, r_efree_ok, r_ebest_ok, r_any;
    logic [1:0]    r_eown;          // owned entries, saturating at two
    logic [DW-1:0] r_sown;          // owner under check in the entry sweep
    logic [DEVICE_SLOTS-1:0] r_mark;  // devices aged out in this sweep
    logic [COUNT_W-1:0] r_count;

    // result being built
    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_dslot, r_res_eslot;
    logic [COUNT_W-1:0] r_res_seen;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_USER_W-1:0] r_m_user;

    // input field views
    logic [KEY_BITS-1:0] in_key;
    t_func               in_func;
    assign in_key  = s_axis_tdata[KEY_BITS-1:0];
    assign in_func = t_func'(s_axis_tuser[1:0]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // shared compare datapath: one slot of each table per cycle
    logic          dv_match;
    logic          d_aged, e_aged;
    logic          e_own, e_eff, e_kind;
    logic [TIME_W-1:0] d_age, e_age;
    logic [EW-1:0] e_pick;
    logic [DW-1:0] claim_d;

    assign dv_match = r_dev_valid[r_di] && (r_dev_key[r_di] == r_key);
    assign d_age    = r_now - r_dev_time[r_di];
    assign d_aged   = r_dev_valid[r_di] && (d_age > r_dev_win);
    assign e_age    = r_now - r_ent_time[r_ei];
    assign e_aged   = r_ent_valid[r_ei] && (e_age > r_ent_win);
    assign e_own    = (r_ent_owner[r_ei] == r_dsel);
    // an evicted device's entries count as free while the claim pass runs
    assign e_eff    = r_ent_valid[r_ei] && !(r_evict && e_own);
    assign e_kind   = (r_ent_kind[r_ei] == r_kind);
    assign e_pick   = r_ematch_ok ? r_ematch : (r_efree_ok ? r_efree : r_ebest);
    assign claim_d  = r_dfree_ok ? r_dfree : r_dlru;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dev_win    <= '0;
            r_ent_win    <= '0;
            r_dev_valid  <= '0;
            r_wait_valid <= '0;
            r_ent_valid  <= '0;
            r_order_cnt  <= '0;
            r_held       <= '0;
            r_drops      <= '0;
            r_decodes    <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DEVICE_WINDOW: r_dev_win <= i_cfg_data;
                    REG_ENTRY_WINDOW:  r_ent_win <= i_cfg_data;
                    default: ;
                endcase
            end
            // a new beat loaded from the done state takes over the output register
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key  <= in_key;
                        r_kind <= s_axis_tdata[79:64];
                        r_fits <= s_axis_tdata[81];
                        r_now  <= s_axis_tdata[113:82];
                        r_dec  <= s_axis_tuser[2];
                        r_res_dslot <= '0;
                        r_res_eslot <= '0;
                        r_res_seen  <= '0;
                        r_di <= '0;
                        r_ei <= '0;
                        unique case (in_func)
                            FN_RECORD: begin
                                if (!s_axis_tdata[80]) begin
                                    r_drops      <= r_drops + 1'b1;
                                    r_res_status <= ST_MALFORMED;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_dfound   <= 1'b0;
                                    r_dfree_ok <= 1'b0;
                                    r_dlru     <= '0;
                                    r_state    <= S_DSCAN;
                                end
                            end
                            FN_SWEEP: begin
                                r_res_status <= ST_SWEPT;
                                r_mark       <= '0;
                                r_state      <= (r_dev_win != '0) ? S_SWDEV : S_SWENT;
                            end
                            FN_CLEAR: begin
                                r_dev_valid  <= '0;
                                r_wait_valid <= '0;
                                r_ent_valid  <= '0;
                                r_order_cnt  <= '0;
                                r_held       <= '0;
                                r_drops      <= '0;
                                r_decodes    <= '0;
                                r_res_status <= ST_CLEARED;
                                r_state      <= S_DONE;
                            end
                            default: ;
                        endcase
                    end
                end

                // device lookup, first free slot and least recent slot in one pass
                S_DSCAN: begin
                    if (dv_match && !r_dfound) begin
                        r_dfound <= 1'b1;
                        r_dsel   <= r_di;
                    end
                    if (!r_dev_valid[r_di] && !r_dfree_ok) begin
                        r_dfree_ok <= 1'b1;
                        r_dfree    <= r_di;
                    end
                    if (r_dev_order[r_di] < r_dev_order[r_dlru]) begin
                        r_dlru <= r_di;
                    end
                    if (r_di == DEV_LAST) begin
                        r_state <= S_DDEC;
                    end else begin
                        r_di <= r_di + 1'b1;
                    end
                end

                S_DDEC: begin
                    if (r_dec && !r_dfound) begin
                        r_pi        <= '0;
                        r_pmatch_ok <= 1'b0;
                        r_pfree_ok  <= 1'b0;
                        r_plru      <= '0;
                        r_state     <= S_PSCAN;
                    end else begin
                        r_state <= S_POST;
                    end
                end

                S_PSCAN: begin
                    if (r_wait_valid[r_pi] && (r_wait_key[r_pi] == r_key) && !r_pmatch_ok) begin
                        r_pmatch_ok <= 1'b1;
                        r_pmatch    <= r_pi;
                    end
                    if (!r_wait_valid[r_pi] && !r_pfree_ok) begin
                        r_pfree_ok <= 1'b1;
                        r_pfree    <= r_pi;
                    end
                    if (r_wait_order[r_pi] < r_wait_order[r_plru]) begin
                        r_plru <= r_pi;
                    end
                    if (r_pi == PEN_LAST) begin
                        r_state <= S_PDEC;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                    end
                end

                S_PDEC: begin
                    if (r_pmatch_ok) begin
                        // second sighting: leaves the pending table whatever follows
                        r_wait_valid[r_pmatch] <= 1'b0;
                        r_state <= S_POST;
                    end else begin
                        r_wait_key[r_pfree_ok ? r_pfree : r_plru]   <= r_key;
                        r_wait_order[r_pfree_ok ? r_pfree : r_plru] <= r_order_cnt + 1'b1;
                        r_wait_valid[r_pfree_ok ? r_pfree : r_plru] <= 1'b1;
                        r_order_cnt  <= r_order_cnt + 1'b1;
                        r_res_status <= ST_PENDING;
                        r_state      <= S_DONE;
                    end
                end

                S_POST: begin
                    r_count <= (r_dfound ? r_dev_hits[r_dsel] : '0) + 1'b1;
                    if (!r_fits) begin
                        r_drops      <= r_drops + 1'b1;
                        r_res_status <= ST_TOO_LONG;
                        r_state      <= S_DONE;
                    end else begin
                        r_evict <= !r_dfound && !r_dfree_ok;
                        if (!r_dfound) begin
                            // claim a slot and clear it in full
                            r_dsel               <= claim_d;
                            r_dev_key[claim_d]   <= r_key;
                            r_dev_valid[claim_d] <= 1'b1;
                            r_dev_hits[claim_d]  <= '0;
                            r_dev_time[claim_d]  <= '0;
                            r_dev_order[claim_d] <= '0;
                            if (r_dfree_ok) begin
                                r_held <= r_held + 1'b1;
                            end
                        end
                        r_ei        <= '0;
                        r_ematch_ok <= 1'b0;
                        r_efree_ok  <= 1'b0;
                        r_ebest_ok  <= 1'b0;
                        r_eown      <= '0;
                        r_state     <= S_ESCAN;
                    end
                end

                // entry lookup, free slot, owned count and oldest owned entry
                S_ESCAN: begin
                    if (r_evict && r_ent_valid[r_ei] && e_own) begin
                        r_ent_valid[r_ei] <= 1'b0;
                    end
                    if (e_eff && e_own && e_kind && !r_ematch_ok) begin
                        r_ematch_ok <= 1'b1;
                        r_ematch    <= r_ei;
                    end
                    if (!e_eff && !r_efree_ok) begin
                        r_efree_ok <= 1'b1;
                        r_efree    <= r_ei;
                    end
                    if (e_eff && e_own) begin
                        if (r_eown != 2'd2) begin
                            r_eown <= r_eown + 1'b1;
                        end
                        if (!r_ebest_ok || (r_ent_order[r_ei] < r_ent_order[r_ebest])) begin
                            r_ebest_ok <= 1'b1;
                            r_ebest    <= r_ei;
                        end
                    end
                    if (r_ei == ENT_LAST) begin
                        r_state <= S_EDEC;
                    end else begin
                        r_ei <= r_ei + 1'b1;
                    end
                end

                S_EDEC: begin
                    if (!r_ematch_ok && !r_efree_ok && (r_eown != 2'd2)) begin
                        r_drops      <= r_drops + 1'b1;
                        r_res_status <= ST_NO_ROOM;
                    end else begin
                        r_ent_valid[e_pick] <= 1'b1;
                        r_ent_owner[e_pick] <= r_dsel;
                        r_ent_kind[e_pick]  <= r_kind;
                        r_ent_time[e_pick]  <= r_now;
                        r_ent_order[e_pick] <= r_order_cnt + 1'b1;
                        r_dev_time[r_dsel]  <= r_now;
                        r_dev_order[r_dsel] <= r_order_cnt + 1'b1;
                        r_dev_hits[r_dsel]  <= r_count;
                        r_order_cnt         <= r_order_cnt + 1'b1;
                        if (r_dec) begin
                            r_decodes <= r_decodes + 1'b1;
                        end
                        r_res_status <= ST_STORED;
                        r_res_dslot  <= SLOT_W'(r_dsel);
                        r_res_eslot  <= SLOT_W'(e_pick);
                        r_res_seen   <= r_count;
                    end
                    r_state <= S_DONE;
                end

                // sweep: idle devices, then their entries
                S_SWDEV: begin
                    if (d_aged) begin
                        r_mark[r_di]      <= 1'b1;
                        r_dev_valid[r_di] <= 1'b0;
                        r_held            <= r_held - 1'b1;
                    end
                    if (r_di == DEV_LAST) begin
                        r_ei    <= '0;
                        r_state <= (r_mark != '0 || d_aged) ? S_SWDFR : S_SWENT;
                    end else begin
                        r_di <= r_di + 1'b1;
                    end
                end

                S_SWDFR: begin
                    if (r_ent_valid[r_ei] && r_mark[r_ent_owner[r_ei]]) begin
                        r_ent_valid[r_ei] <= 1'b0;
                    end
                    if (r_ei == ENT_LAST) begin
                        r_ei    <= '0;
                        r_state <= S_SWENT;
                    end else begin
                        r_ei <= r_ei + 1'b1;
                    end
                end

                S_SWENT: begin
                    if (r_ent_win == '0) begin
                        r_state <= S_DONE;
                    end else if (e_aged) begin
                        r_ent_valid[r_ei] <= 1'b0;
                        r_sown  <= r_ent_owner[r_ei];
                        r_ej    <= '0;
                        r_any   <= 1'b0;
                        r_state <= S_SWECHK;
                    end else if (r_ei == ENT_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ei <= r_ei + 1'b1;
                    end
                end

                // does the owner of the freed entry keep any entry
                S_SWECHK: begin
                    if (r_ent_valid[r_ej] && (r_ent_owner[r_ej] == r_sown)) begin
                        r_any <= 1'b1;
                    end
                    if (r_ej == ENT_LAST) begin
                        if (!r_any && !(r_ent_valid[r_ej] && (r_ent_owner[r_ej] == r_sown))
                                && r_dev_valid[r_sown]) begin
                            r_dev_valid[r_sown] <= 1'b0;
                            r_held <= r_held - 1'b1;
                        end
                        if (r_ei == ENT_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ei    <= r_ei + 1'b1;
                            r_state <= S_SWENT;
                        end
                    end else begin
                        r_ej <= r_ej + 1'b1;
                    end
                end

                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_res_status;
                        r_m_data  <= {1'b0, r_decodes, r_drops, SLOT_W'(r_held),
                                      r_res_seen, r_res_eslot, r_res_dslot};
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/dtha_checker.sv
// dtha_checker: port-level assertions on the device table result stream
// depends on dtha_pkg; bound to device_table_two_hit_admission_top
`default_nettype none

module dtha_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [dtha_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input wire logic [dtha_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import dtha_pkg::*;

    // status code stays within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_CLEARED))
        else $error("result status out of range");

    // slot and seen fields are zero unless stored
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_STORED)) |-> (m_axis_tdata[41:0] == '0))
        else $error("slot fields set on a result that stored nothing");

    // a stored sighting has been seen at least once
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_STORED)) |-> (m_axis_tdata[41:10] != '0))
        else $error("stored result with zero sightings");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind device_table_two_hit_admission_top dtha_checker u_dtha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
